[design/ss7_mtp2_link_control_unit_defines.svh]
// Assertion macros shared by the link control unit.
`ifndef SS7_MTP2_LINK_CONTROL_UNIT_DEFINES_SVH
`define SS7_MTP2_LINK_CONTROL_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SS7L_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ss7 link control: same-cycle check failed");

// Next-cycle implication.
`define SS7L_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ss7 link control: next-cycle check failed");

`endif

[design/ss7l_pkg.sv]
package ss7l_pkg;

  localparam int SEQ_BITS = 7;

  // Link status codes
  localparam logic [2:0] ST_O  = 3'd0;
  localparam logic [2:0] ST_N  = 3'd1;
  localparam logic [2:0] ST_E  = 3'd2;
  localparam logic [2:0] ST_OS = 3'd3;
  localparam logic [2:0] ST_B  = 3'd5;

  // Event opcodes
  localparam logic [3:0] OP_RX     = 4'd0;
  localparam logic [3:0] OP_SEND   = 4'd1;
  localparam logic [3:0] OP_TICK   = 4'd2;
  localparam logic [3:0] OP_ERROR  = 4'd3;
  localparam logic [3:0] OP_DOWN   = 4'd4;
  localparam logic [3:0] OP_UP     = 4'd5;
  localparam logic [3:0] OP_ALIGN  = 4'd6;
  localparam logic [3:0] OP_PAUSE  = 4'd7;
  localparam logic [3:0] OP_RESUME = 4'd8;

  // Transmit kinds
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_FISU   = 3'd1;
  localparam logic [2:0] K_LSSU   = 3'd2;
  localparam logic [2:0] K_MSU    = 3'd3;
  localparam logic [2:0] K_RESEND = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_ERRORS   = 3'd0;
  localparam logic [2:0] REG_AUTOSTART    = 3'd1;
  localparam logic [2:0] REG_FILL_LINK    = 3'd2;
  localparam logic [2:0] REG_FLUSH        = 3'd3;
  localparam logic [2:0] REG_RESEND_TICKS = 3'd4;
  localparam logic [2:0] REG_ABORT_TICKS  = 3'd5;
  localparam logic [2:0] REG_FILL_TICKS   = 3'd6;

  typedef struct packed {
    logic [8:0]  max_errors;
    logic        autostart;
    logic        fill_link;
    logic        flush_on_proving;
    logic [15:0] resend_ticks;
    logic [15:0] abort_ticks;
    logic [15:0] fill_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [6:0] rx_bsn;
    logic       rx_bib;
    logic [6:0] rx_fsn;
    logic       rx_fib;
    logic [5:0] rx_li;
    logic [8:0] rx_total_length;
    logic [7:0] rx_status;
    logic       emergency;
    logic [8:0] msu_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  local_status;
    logic [2:0]  remote_status;
    logic [2:0]  target_status;
    logic [6:0]  local_bsn;
    logic [6:0]  local_fsn;
    logic        local_bib;
    logic        local_fib;
    logic [7:0]  last_nak_fsn;
    logic [6:0]  last_acked_fsn;
    logic        last_remote_bib;
    logic [6:0]  queued_count;
    logic [16:0] error_score;
    logic [13:0] interval_timer;
    logic [15:0] abort_timer;
    logic [15:0] resend_timer;
    logic [15:0] fill_timer;
    logic        interval_on;
    logic        abort_on;
    logic        resend_on;
    logic        congested;
  } st_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] bsn;
    logic       bib;
    logic [6:0] fsn;
    logic       fib;
    logic [5:0] li;
    logic [2:0] status;
  } tx_t;

  typedef struct packed {
    logic       deliver_msu;
    logic [6:0] acked_count;
    logic       operational;
    logic       rejected;
  } res_t;

  typedef struct packed {
    tx_t [2:0]  tx;
    logic [1:0] n;
    res_t       res;
  } batch_t;

endpackage

[design/ss7l_step.sv]
module ss7l_step import ss7l_pkg::*; #(
  parameter int MAX_QUEUED = 127
) (
  input  item_t  item,
  input  st_t    st,
  input  cfg_t   cfg,
  output st_t    st_next,
  output batch_t batch
);

  localparam logic [6:0] MaxQ = 7'(MAX_QUEUED);

  typedef struct packed {
    st_t        s;
    tx_t [2:0]  tx;
    logic [1:0] n;
  } work_t;

  function automatic logic f_align(logic [2:0] v);
    return v == ST_N || v == ST_E;
  endfunction

  function automatic logic f_aligned(st_t s);
    return f_align(s.local_status) && f_align(s.remote_status);
  endfunction

  function automatic logic f_oper(st_t s);
    return f_aligned(s) && !s.interval_on;
  endfunction

  function automatic work_t f_emit(work_t w, logic [2:0] kind, logic [6:0] fsn,
                                   logic [5:0] li, logic [2:0] sts);
    work_t r;
    r = w;
    if (w.n != 2'd3) begin
      r.tx[w.n] = '{kind: kind, bsn: w.s.local_bsn, bib: w.s.local_bib, fsn: fsn,
                    fib: w.s.local_fib, li: li, status: sts};
      r.n = w.n + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t f_set_local(work_t w, logic [2:0] v);
    work_t r;
    r = w;
    if (v != w.s.local_status) begin
      r.s.local_status = v;
      r.s.fill_timer = '0;
    end
    return r;
  endfunction

  function automatic work_t f_lssu(work_t w, logic [15:0] ft);
    work_t r;
    r = f_emit(w, K_LSSU, w.s.local_fsn, 6'd1, w.s.local_status);
    r.s.fill_timer = ft;
    return r;
  endfunction

  function automatic work_t f_fisu(work_t w, logic [15:0] ft);
    work_t r;
    r = f_emit(w, K_FISU, w.s.local_fsn, 6'd0, 3'd0);
    r.s.fill_timer = ft;
    return r;
  endfunction

  function automatic work_t f_reset_seq(work_t w);
    work_t r;
    r = w;
    r.s.local_bsn = 7'h7f;
    r.s.local_fsn = 7'h7f;
    r.s.local_bib = 1'b1;
    r.s.local_fib = 1'b1;
    return r;
  endfunction

  function automatic work_t f_abort(work_t w, logic retry, logic [15:0] ft);
    work_t r;
    r = w;
    if (!retry) r.s.target_status = ST_OS;
    r = f_set_local(r, ST_OS);
    r.s.interval_on = 1'b1;
    r.s.interval_timer = 14'd1000;
    r.s.abort_on = 1'b0;
    r.s.resend_on = 1'b0;
    r.s.abort_timer = '0;
    r.s.resend_timer = '0;
    r.s.error_score = '0;
    r = f_reset_seq(r);
    r.s.fill_timer = '0;
    r = f_lssu(r, ft);
    return r;
  endfunction

  function automatic work_t f_start(work_t w, logic emg, logic [15:0] ft);
    work_t r;
    r = f_reset_seq(w);
    if (r.s.local_status != ST_OS) begin
      r = f_set_local(r, ST_OS);
      r = f_lssu(r, ft);
    end
    r.s.target_status = emg ? ST_E : ST_N;
    r.s.abort_on = 1'b0;
    r.s.resend_on = 1'b0;
    r.s.abort_timer = '0;
    r.s.resend_timer = '0;
    r = f_set_local(r, ST_O);
    r.s.interval_on = 1'b1;
    r.s.interval_timer = 14'd5000;
    r = f_lssu(r, ft);
    return r;
  endfunction

  work_t      w;
  logic       rej, deliver, unal, tout, abt, rsd, proving;
  logic [6:0] acked, diff, k, c;
  logic [8:0] len, me, thr, tm3;
  logic [2:0] rs;

  always_comb begin
    w = '{s: st, tx: '0, n: 2'd0};
    rej = 1'b0;
    deliver = 1'b0;
    acked = '0;
    len = '0;
    me = '0;
    thr = '0;
    rs = '0;
    unal = 1'b0;
    tout = 1'b0;
    abt = 1'b0;
    rsd = 1'b0;
    proving = 1'b0;
    diff = '0;
    k = '0;
    c = '0;
    tm3 = item.rx_total_length - 9'd3;
    case (item.opcode)
      OP_RX: begin
        len = {3'd0, item.rx_li};
        if (item.rx_total_length < 9'd3) begin
          rej = 1'b1;
        end else if (item.rx_li == 6'h3f && item.rx_total_length > 9'd66) begin
          len = tm3;
        end else if (len != tm3) begin
          rej = 1'b1;
        end
        if (!rej) begin
          if (w.s.error_score != '0 && f_oper(w.s)) w.s.error_score = w.s.error_score - 17'd1;
          if (len == 9'd1 || len == 9'd2) begin
            // Received LSSU status
            rs = item.rx_status[2:0];
            unal = !f_aligned(w.s);
            w.s.remote_status = rs;
            if (rs == ST_B) begin
              if (unal) w = f_abort(w, cfg.autostart, cfg.fill_ticks);
              else w.s.congested = 1'b1;
            end else if (rs == ST_O || rs == ST_N || rs == ST_E) begin
              if (w.s.local_status == ST_OS) begin
                if (w.s.target_status != ST_OS) w = f_set_local(w, ST_O);
              end else begin
                proving = 1'b0;
                if (unal && f_aligned(w.s)) begin
                  proving = 1'b1;
                  w.s.interval_on = 1'b1;
                  w.s.interval_timer = (rs == ST_E) ? 14'd512 : 14'd8192;
                end
                if (!proving) w = f_set_local(w, w.s.target_status);
              end
            end else if (!w.s.interval_on) begin
              if (w.s.target_status != ST_OS) w = f_abort(w, cfg.autostart, cfg.fill_ticks);
            end else if (w.s.local_status != ST_OS && w.s.local_status != ST_O) begin
              w.s.interval_on = 1'b0;
              w.s.interval_timer = '0;
            end
          end else if (len == 9'd0 && cfg.fill_link && !f_aligned(w.s)) begin
            w.s.fill_timer = '0;
          end
          diff = item.rx_fsn - w.s.local_bsn;
          if (f_aligned(w.s)) begin
            if (diff > 7'd1) begin
              if ({1'b0, item.rx_fsn} != w.s.last_nak_fsn) begin
                w.s.last_nak_fsn = {1'b0, item.rx_fsn};
                w.s.local_bib = ~w.s.local_bib;
              end
            end else begin
              w.s.last_nak_fsn = 8'd128;
            end
            if (w.s.last_remote_bib != item.rx_bib) begin
              w.s.last_remote_bib = item.rx_bib;
              w.s.resend_on = 1'b1;
              w.s.resend_timer = '0;
            end
            // Release acknowledged MSUs
            if (w.s.last_acked_fsn != item.rx_bsn) begin
              k = item.rx_bsn - w.s.last_acked_fsn;
              c = (k < w.s.queued_count) ? k : w.s.queued_count;
              w.s.queued_count = w.s.queued_count - c;
              w.s.last_acked_fsn = item.rx_bsn;
              if (w.s.queued_count == '0) begin
                w.s.resend_on = 1'b0;
                w.s.abort_on = 1'b0;
                w.s.resend_timer = '0;
                w.s.abort_timer = '0;
              end
              if (c != '0) begin
                w.s.abort_on = w.s.resend_on;
                w.s.abort_timer = w.s.resend_on ? cfg.abort_ticks : 16'd0;
              end
            end
            acked = c;
            if (w.s.interval_on && diff == 7'd1) w.s.interval_timer = '0;
          end else begin
            w.s.local_bsn = item.rx_fsn;
            w.s.local_bib = item.rx_fib;
            w.s.last_acked_fsn = item.rx_bsn;
            w.s.last_remote_bib = item.rx_bib;
            w.s.fill_timer = '0;
          end
          if (len >= 9'd3) begin
            if (!(diff == 7'd1 && f_oper(w.s))) begin
              rej = 1'b1;
            end else begin
              w.s.local_bsn = item.rx_fsn;
              w.s.fill_timer = '0;
              deliver = 1'b1;
            end
          end
        end
      end
      OP_SEND: begin
        if (item.msu_length < 9'd3 || !f_oper(w.s) || w.s.queued_count >= MaxQ) begin
          rej = 1'b1;
        end else begin
          w.s.local_fsn = w.s.local_fsn + 7'd1;
          w.s.fill_timer = '0;
          w = f_emit(w, K_MSU, w.s.local_fsn,
                     (item.msu_length > 9'd63) ? 6'h3f : item.msu_length[5:0], 3'd0);
          w.s.queued_count = w.s.queued_count + 7'd1;
          w = f_fisu(w, cfg.fill_ticks);
          if (!w.s.abort_on) begin
            w.s.abort_on = 1'b1;
            w.s.abort_timer = cfg.abort_ticks;
          end
          if (!w.s.resend_on) begin
            w.s.resend_on = 1'b1;
            w.s.resend_timer = cfg.resend_ticks;
          end
        end
      end
      OP_TICK: begin
        if (w.s.interval_timer != '0) w.s.interval_timer = w.s.interval_timer - 14'd1;
        tout = w.s.interval_on && w.s.interval_timer == '0;
        if (tout) w.s.interval_on = 1'b0;
        if (w.s.abort_timer != '0) w.s.abort_timer = w.s.abort_timer - 16'd1;
        abt = w.s.abort_on && w.s.abort_timer == '0;
        if (w.s.resend_timer != '0) w.s.resend_timer = w.s.resend_timer - 16'd1;
        rsd = w.s.resend_on && w.s.resend_timer == '0;
        if (w.s.fill_timer != '0) w.s.fill_timer = w.s.fill_timer - 16'd1;
        if (abt) begin
          w = f_abort(w, cfg.autostart, cfg.fill_ticks);
        end else begin
          if (rsd) w.s.resend_on = 1'b0;
          if (f_oper(w.s)) begin
            if (tout && w.s.queued_count != '0) begin
              if (cfg.flush_on_proving || w.s.queued_count >= 7'd64) begin
                w.s.queued_count = '0;
              end else begin
                w = f_fisu(w, cfg.fill_ticks);
                rsd = 1'b1;
                w.s.last_acked_fsn = w.s.local_fsn;
                w.s.local_fsn = w.s.local_fsn + w.s.queued_count;
              end
            end
            if (rsd) begin
              w.s.local_fib = w.s.last_remote_bib;
              if (w.s.queued_count != '0) begin
                w = f_emit(w, K_RESEND, w.s.last_acked_fsn + 7'd1, 6'd0, 3'd0);
                w.s.resend_on = 1'b1;
                w.s.resend_timer = cfg.resend_ticks;
                w.s.fill_timer = '0;
              end
            end
          end else if (tout && w.s.local_status == ST_OS && w.s.target_status != ST_OS) begin
            w = f_set_local(w, ST_O);
          end
          if (w.s.fill_timer == '0) begin
            if (f_oper(w.s)) w = f_fisu(w, cfg.fill_ticks);
            else w = f_lssu(w, cfg.fill_ticks);
          end
        end
      end
      OP_ERROR: begin
        me = cfg.max_errors;
        if (me < 9'd8) me = 9'd8;
        if (me > 9'd256) me = 9'd256;
        w.s.error_score = w.s.error_score + 17'd256;
        thr = f_oper(w.s) ? me : ((w.s.remote_status == ST_E) ? 9'd1 : 9'd4);
        if (w.s.error_score[16:8] >= thr) w = f_abort(w, cfg.autostart, cfg.fill_ticks);
      end
      OP_DOWN: w = f_abort(w, cfg.autostart, cfg.fill_ticks);
      OP_UP, OP_RESUME: begin
        if (!f_aligned(w.s) && cfg.autostart) w = f_start(w, item.emergency, cfg.fill_ticks);
      end
      OP_ALIGN: w = f_start(w, item.emergency, cfg.fill_ticks);
      OP_PAUSE: w = f_abort(w, 1'b0, cfg.fill_ticks);
      default: ;
    endcase
    st_next = w.s;
    batch.tx = w.tx;
    batch.n = (w.n == 2'd0) ? 2'd1 : w.n;
    batch.res = '{deliver_msu: deliver, acked_count: acked, operational: f_oper(w.s),
                  rejected: rej};
  end

endmodule

[design/ss7l_txq.sv]
module ss7l_txq import ss7l_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  batch_t batch_in,
  output logic   free,
  output logic   busy,
  output logic   at_last,
  output tx_t    tx,
  output res_t   res,
  input  logic   ready
);

  batch_t     batch;
  logic [1:0] idx;

  assign at_last = idx == batch.n - 2'd1;
  assign free = !busy || (ready && at_last);
  assign tx = batch.tx[idx];
  assign res = batch.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (load && free) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && ready) begin
      if (at_last) busy <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) batch <= batch_in;
  end

endmodule

[design/ss7_mtp2_link_control_unit.sv]
// Q.703 signalling-link control with basic error correction.
// Slave stream: one event per transfer; tuser carries the opcode, tdata the
// received header fields and the send request fields. Master stream: one
// to three results per event, tuser is the transmit kind, tlast marks the
// final result of an event. Configuration writes go through cfg_we,
// cfg_index and cfg_data and must be issued only while the block is idle.
// An event waits in the input register until the result buffer is free,
// is worked through the step logic in a single pass as it is loaded into
// the buffer, and its first result shows on the master side in the cycle
// after that load. Throughput: one event per cycle while each event yields
// one result and the receiver does not stall; an event with more results
// holds the next one back, as the buffer gives one result per ready cycle.
// Reset (synchronous, active high) returns the link to out of service with
// the sequence numbers at 127, all timers idle and the registers at their
// defaults. When the receiver stalls, the result buffer holds its entry,
// the input register holds one waiting event, and s_axis_tready drops.
module ss7_mtp2_link_control_unit import ss7l_pkg::*; #(
  parameter int MAX_QUEUED = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: rx_bsn, rx_bib, rx_fsn, rx_fib, rx_li, rx_total_length,
  //        rx_status, emergency, msu_length, zero fill
  input  logic [55:0] s_axis_tdata,
  // tuser: opcode
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: send_bsn, send_bib, send_fsn, send_fib, send_li, send_status,
  //        deliver_msu, acked_count, operational, rejected, zero fill
  output logic [39:0] m_axis_tdata,
  // tuser: send_kind
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "ss7_mtp2_link_control_unit_defines.svh"

  cfg_t   cfg;
  st_t    state, state_next;
  item_t  item;
  logic   in_full, take, q_free, at_last;
  batch_t batch;
  tx_t    tx;
  res_t   res;

  // Advance the event out of the input register once the buffer frees up
  assign take = in_full && q_free;
  assign s_axis_tready = !in_full || q_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  // Capture the event payload on each slave transfer
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= '{opcode: s_axis_tuser, rx_bsn: s_axis_tdata[6:0], rx_bib: s_axis_tdata[7],
                rx_fsn: s_axis_tdata[14:8], rx_fib: s_axis_tdata[15],
                rx_li: s_axis_tdata[21:16], rx_total_length: s_axis_tdata[30:22],
                rx_status: s_axis_tdata[38:31], emergency: s_axis_tdata[39],
                msu_length: s_axis_tdata[48:40]};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{max_errors: 9'd64, autostart: 1'b1, fill_link: 1'b1, flush_on_proving: 1'b1,
               resend_ticks: 16'd250, abort_ticks: 16'd5000, fill_ticks: 16'd20};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ERRORS:   cfg.max_errors <= cfg_data[8:0];
        REG_AUTOSTART:    cfg.autostart <= cfg_data[0];
        REG_FILL_LINK:    cfg.fill_link <= cfg_data[0];
        REG_FLUSH:        cfg.flush_on_proving <= cfg_data[0];
        REG_RESEND_TICKS: cfg.resend_ticks <= cfg_data;
        REG_ABORT_TICKS:  cfg.abort_ticks <= cfg_data;
        REG_FILL_TICKS:   cfg.fill_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Link state: update once per event
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{local_status: ST_OS, remote_status: ST_O, target_status: ST_OS,
                 local_bsn: 7'h7f, local_fsn: 7'h7f, local_bib: 1'b1, local_fib: 1'b1,
                 last_nak_fsn: 8'd128, last_acked_fsn: 7'h7f, last_remote_bib: 1'b1,
                 queued_count: 7'd0, error_score: 17'd0, interval_timer: 14'd0,
                 abort_timer: 16'd0, resend_timer: 16'd0, fill_timer: 16'd0,
                 interval_on: 1'b0, abort_on: 1'b0, resend_on: 1'b0, congested: 1'b0};
    end else if (take) begin
      state <= state_next;
    end
  end

  ss7l_step #(.MAX_QUEUED(MAX_QUEUED)) u_step (
    .item    (item),
    .st      (state),
    .cfg     (cfg),
    .st_next (state_next),
    .batch   (batch)
  );

  ss7l_txq u_txq (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .batch_in (batch),
    .free     (q_free),
    .busy     (m_axis_tvalid),
    .at_last  (at_last),
    .tx       (tx),
    .res      (res),
    .ready    (m_axis_tready)
  );

  assign m_axis_tuser = tx.kind;
  assign m_axis_tlast = at_last;
  assign m_axis_tdata = {5'd0, res.rejected, res.operational, res.acked_count,
                         res.deliver_msu, tx.status, tx.li, tx.fib, tx.fsn, tx.bib, tx.bsn};

  `SS7L_ASSERT_NEXT(a_hold_event, in_full && !take, in_full)
  `SS7L_ASSERT_NEXT(a_load_shows, take, m_axis_tvalid)
  `SS7L_ASSERT_NOW(a_free_idle, !m_axis_tvalid, q_free)

endmodule

[verif/ss7_link_checker.sv]
// Link control checker: watches the event stream and the configuration port,
// predicts the transmitted headers of every event and compares them with the
// result stream in order.
module ss7_link_checker import ss7l_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_QUEUED = 127;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] bsn;
    logic       bib;
    logic [6:0] fsn;
    logic       fib;
    logic [5:0] li;
    logic [2:0] status;
    logic       deliver;
    logic [6:0] acked;
    logic       oper;
    logic       rej;
    logic       last;
  } hdr_t;

  hdr_t hdr_q[$];

  // link configuration
  logic [8:0]  max_errors;
  logic        autostart, fill_link, flush_on_proving;
  logic [15:0] resend_ticks, abort_ticks, fill_ticks;

  // link state
  logic [2:0]  lnk_local, lnk_remote, lnk_target;
  logic [6:0]  lnk_bsn, lnk_fsn;
  logic        lnk_bib, lnk_fib;
  logic [7:0]  nak_fsn;
  logic [6:0]  acked_fsn;
  logic        remote_bib;
  logic [6:0]  queued;
  logic [16:0] err_score;
  logic        congested;
  logic [13:0] interval_t;
  logic [15:0] abort_t, resend_t, fill_t;
  logic        interval_on, abort_on, resend_on;

  tx_t tx_buf[3];
  int  tx_n;

  function automatic bit is_align(logic [2:0] s);
    return s == ST_N || s == ST_E;
  endfunction

  function automatic bit aligned_now();
    return is_align(lnk_local) && is_align(lnk_remote);
  endfunction

  function automatic bit oper_now();
    return aligned_now() && !interval_on;
  endfunction

  task automatic put_tx(logic [2:0] kind, logic [6:0] fsn, logic [5:0] li, logic [2:0] st);
    if (tx_n < 3) begin
      tx_buf[tx_n] = '{kind, lnk_bsn, lnk_bib, fsn, lnk_fib, li, st};
      tx_n++;
    end
  endtask

  task automatic set_local(logic [2:0] s);
    if (s != lnk_local) begin
      lnk_local = s;
      fill_t = 0;
    end
  endtask

  task automatic send_lssu();
    put_tx(K_LSSU, lnk_fsn, 6'd1, lnk_local);
    fill_t = fill_ticks;
  endtask

  task automatic send_fisu();
    put_tx(K_FISU, lnk_fsn, 6'd0, 3'd0);
    fill_t = fill_ticks;
  endtask

  task automatic reset_seq();
    lnk_bsn = 7'h7f;
    lnk_fsn = 7'h7f;
    lnk_bib = 1'b1;
    lnk_fib = 1'b1;
  endtask

  task automatic abort_align(bit retry);
    if (!retry) lnk_target = ST_OS;
    set_local(ST_OS);
    interval_on = 1'b1;
    interval_t = 14'd1000;
    abort_on = 1'b0;
    resend_on = 1'b0;
    abort_t = 0;
    resend_t = 0;
    err_score = 0;
    reset_seq();
    fill_t = 0;
    send_lssu();
  endtask

  task automatic start_align(bit emg);
    reset_seq();
    if (lnk_local != ST_OS) begin
      set_local(ST_OS);
      send_lssu();
    end
    lnk_target = emg ? ST_E : ST_N;
    abort_on = 1'b0;
    resend_on = 1'b0;
    abort_t = 0;
    resend_t = 0;
    set_local(ST_O);
    interval_on = 1'b1;
    interval_t = 14'd5000;
    send_lssu();
  endtask

  function automatic bit start_proving();
    if (!aligned_now()) return 1'b0;
    interval_on = 1'b1;
    interval_t = (lnk_remote == ST_E) ? 14'd512 : 14'd8192;
    return 1'b1;
  endfunction

  task automatic take_lssu(logic [2:0] st);
    bit unaligned;
    unaligned = !aligned_now();
    lnk_remote = st;
    if (st == ST_B) begin
      if (unaligned) abort_align(autostart);
      else congested = 1'b1;
    end else if (st == ST_O || st == ST_N || st == ST_E) begin
      if (lnk_local == ST_OS) begin
        if (lnk_target != ST_OS) set_local(ST_O);
      end else if (!(unaligned && start_proving())) begin
        set_local(lnk_target);
      end
    end else if (!interval_on) begin
      if (lnk_target != ST_OS) abort_align(autostart);
    end else if (lnk_local != ST_OS && lnk_local != ST_O) begin
      interval_on = 1'b0;
      interval_t = 0;
    end
  endtask

  // release acknowledged MSUs, return how many left the queue
  function automatic logic [6:0] release_acked(logic [6:0] bsn);
    logic [6:0] k, c;
    if (acked_fsn == bsn) return 7'd0;
    k = bsn - acked_fsn;
    c = (k < queued) ? k : queued;
    queued = queued - c;
    acked_fsn = bsn;
    if (queued == 0) begin
      resend_on = 1'b0;
      abort_on = 1'b0;
      resend_t = 0;
      abort_t = 0;
    end
    if (c != 0) begin
      abort_on = resend_on;
      abort_t = resend_on ? abort_ticks : 16'd0;
    end
    return c;
  endfunction

  task automatic advance_ms();
    bit tout, aborting, resend;
    if (interval_t > 0) interval_t--;
    tout = interval_on && interval_t == 0;
    if (tout) interval_on = 1'b0;
    if (abort_t > 0) abort_t--;
    aborting = abort_on && abort_t == 0;
    if (resend_t > 0) resend_t--;
    resend = resend_on && resend_t == 0;
    if (fill_t > 0) fill_t--;
    if (aborting) begin
      abort_on = 1'b0;
      resend_on = 1'b0;
      abort_t = 0;
      resend_t = 0;
      abort_align(autostart);
      return;
    end
    if (resend) resend_on = 1'b0;
    if (oper_now()) begin
      // proving just ended with MSUs waiting: flush or renumber them
      if (tout && queued != 0) begin
        if (flush_on_proving || queued >= 64) begin
          queued = 0;
        end else begin
          send_fisu();
          resend = 1'b1;
          acked_fsn = lnk_fsn;
          lnk_fsn = lnk_fsn + queued;
        end
      end
      if (resend) begin
        lnk_fib = remote_bib;
        if (queued != 0) begin
          put_tx(K_RESEND, acked_fsn + 7'd1, 6'd0, 3'd0);
          resend_on = 1'b1;
          resend_t = resend_ticks;
          fill_t = 0;
        end
      end
    end else if (tout && lnk_local == ST_OS && lnk_target != ST_OS) begin
      set_local(ST_O);
    end
    if (fill_t == 0) begin
      if (oper_now()) send_fisu();
      else send_lssu();
    end
  endtask

  // work out the results of one event and queue them
  task automatic predict_event(logic [3:0] op, logic [55:0] d);
    logic [6:0] bsn, fsn, diff, acked;
    logic       bib, fib, emg, deliver, rej;
    logic [5:0] li;
    logic [8:0] total, mlen;
    logic [7:0] rst_st;
    int         len, me, thr;
    bsn = d[6:0];
    bib = d[7];
    fsn = d[14:8];
    fib = d[15];
    li = d[21:16];
    total = d[30:22];
    rst_st = d[38:31];
    emg = d[39];
    mlen = d[48:40];
    deliver = 0;
    acked = 0;
    rej = 0;
    tx_n = 0;
    case (op)
      OP_RX: begin
        len = li;
        if (total < 3) begin
          rej = 1;
        end else if (!(li == 63 && total > 66) && int'(li) != int'(total) - 3) begin
          rej = 1;
        end else begin
          if (li == 63 && total > 66) len = int'(total) - 3;
          if (err_score != 0 && oper_now()) err_score--;
          if (len == 1 || len == 2) take_lssu(rst_st[2:0]);
          else if (len == 0 && fill_link && !aligned_now()) fill_t = 0;
          diff = fsn - lnk_bsn;
          if (aligned_now()) begin
            if (diff > 1) begin
              if ({1'b0, fsn} != nak_fsn) begin
                nak_fsn = {1'b0, fsn};
                lnk_bib = ~lnk_bib;
              end
            end else begin
              nak_fsn = 8'd128;
            end
            if (remote_bib != bib) begin
              remote_bib = bib;
              resend_on = 1'b1;
              resend_t = 0;
            end
            acked = release_acked(bsn);
            if (interval_on && diff == 1) interval_t = 0;
          end else begin
            lnk_bsn = fsn;
            lnk_bib = fib;
            acked_fsn = bsn;
            remote_bib = bib;
            fill_t = 0;
          end
          if (len >= 3) begin
            if (!(diff == 1 && oper_now())) begin
              rej = 1;
            end else begin
              lnk_bsn = fsn;
              fill_t = 0;
              deliver = 1;
            end
          end
        end
      end
      OP_SEND: begin
        if (mlen < 3 || !oper_now() || queued >= MAX_QUEUED) begin
          rej = 1;
        end else begin
          lnk_fsn = lnk_fsn + 7'd1;
          fill_t = 0;
          put_tx(K_MSU, lnk_fsn, (mlen > 63) ? 6'd63 : mlen[5:0], 3'd0);
          queued++;
          send_fisu();
          if (!abort_on) begin
            abort_on = 1'b1;
            abort_t = abort_ticks;
          end
          if (!resend_on) begin
            resend_on = 1'b1;
            resend_t = resend_ticks;
          end
        end
      end
      OP_TICK: advance_ms();
      OP_ERROR: begin
        me = max_errors;
        if (me < 8) me = 8;
        if (me > 256) me = 256;
        err_score = err_score + 17'd256;
        thr = oper_now() ? me : ((lnk_remote == ST_E) ? 1 : 4);
        if (int'(err_score >> 8) >= thr) abort_align(autostart);
      end
      OP_DOWN: abort_align(autostart);
      OP_UP, OP_RESUME: begin
        if (!aligned_now() && autostart) start_align(emg);
      end
      OP_ALIGN: start_align(emg);
      OP_PAUSE: abort_align(1'b0);
      default: ;
    endcase
    if (tx_n == 0) begin
      tx_buf[0] = '0;
      tx_n = 1;
    end
    for (int k = 0; k < tx_n; k++)
      hdr_q.push_back('{tx_buf[k].kind, tx_buf[k].bsn, tx_buf[k].bib, tx_buf[k].fsn,
                        tx_buf[k].fib, tx_buf[k].li, tx_buf[k].status, deliver, acked,
                        oper_now(), rej, k == tx_n - 1});
  endtask

  task automatic reset_link();
    max_errors = 9'd64;
    autostart = 1;
    fill_link = 1;
    flush_on_proving = 1;
    resend_ticks = 16'd250;
    abort_ticks = 16'd5000;
    fill_ticks = 16'd20;
    lnk_local = ST_OS;
    lnk_remote = ST_O;
    lnk_target = ST_OS;
    reset_seq();
    nak_fsn = 8'd128;
    acked_fsn = 7'h7f;
    remote_bib = 1;
    queued = 0;
    err_score = 0;
    congested = 0;
    interval_t = 0;
    abort_t = 0;
    resend_t = 0;
    fill_t = 0;
    interval_on = 0;
    abort_on = 0;
    resend_on = 0;
  endtask

  initial begin
    fail_count = 0;
    reset_link();
  end

  assign pending = hdr_q.size();

  always @(posedge clk) begin
    hdr_t got, want;
    if (rst) begin
      reset_link();
      hdr_q.delete();
    end else begin
      // compare the result transfer first; a new event cannot answer in the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7], m_axis_tdata[14:8],
               m_axis_tdata[15], m_axis_tdata[21:16], m_axis_tdata[24:22],
               m_axis_tdata[25], m_axis_tdata[32:26], m_axis_tdata[33],
               m_axis_tdata[34], m_axis_tlast};
        if (hdr_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: unexpected result transfer %h", $realtime, got);
        end else begin
          want = hdr_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%t: mismatch (exp/act) kind %0d/%0d bsn %0d/%0d bib %0d/%0d",
                       $realtime, want.kind, got.kind, want.bsn, got.bsn,
                       want.bib, got.bib);
              $display("  fsn %0d/%0d fib %0d/%0d li %0d/%0d st %0d/%0d dlv %0d/%0d",
                       want.fsn, got.fsn, want.fib, got.fib, want.li, got.li,
                       want.status, got.status, want.deliver, got.deliver);
              $display("  ack %0d/%0d op %0d/%0d rej %0d/%0d last %0d/%0d",
                       want.acked, got.acked, want.oper, got.oper, want.rej, got.rej,
                       want.last, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ERRORS:   max_errors = cfg_data[8:0];
          REG_AUTOSTART:    autostart = cfg_data[0];
          REG_FILL_LINK:    fill_link = cfg_data[0];
          REG_FLUSH:        flush_on_proving = cfg_data[0];
          REG_RESEND_TICKS: resend_ticks = cfg_data;
          REG_ABORT_TICKS:  abort_ticks = cfg_data;
          REG_FILL_TICKS:   fill_ticks = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_event(s_axis_tuser, s_axis_tdata);
    end
  end
endmodule

[verif/ss7_mtp2_link_control_unit_tb.sv]
// Stimulus and verdict for the link control unit. The checker beside the
// block predicts and compares; this module only drives events, register
// writes and receiver stalls.
module ss7_mtp2_link_control_unit_tb;
  import ss7l_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending, cycles = 0;
  bit          stall_on = 0;

  always #5 clk = ~clk;

  ss7_mtp2_link_control_unit dut (.*);

  ss7_link_checker chk (.*);

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver side: stretches with no stalls, stretches with mostly short stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 59) == 0) stall_on <= ~stall_on;
    if (!stall_on) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // hold one event until its transfer; leave valid high for a back-to-back event
  task automatic put_event(logic [3:0] op, logic [6:0] bsn, logic bib, logic [6:0] fsn,
                           logic fib, logic [5:0] li, logic [8:0] total, logic [7:0] st,
                           logic emg, logic [8:0] mlen);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, mlen, emg, st, total, li, fib, fsn, bib, bsn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_simple(logic [3:0] op, logic emg = 0);
    put_event(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              emg, $urandom);
  endtask

  // received unit with a consistent length; li 63 stands for long units
  task automatic put_unit(logic [6:0] bsn, logic bib, logic [6:0] fsn, int len,
                          logic [7:0] st);
    put_event(OP_RX, bsn, bib, fsn, $urandom, (len > 63) ? 6'd63 : len[5:0], len + 3,
              st, $urandom, $urandom);
  endtask

  task automatic put_send(logic [8:0] mlen);
    put_event(OP_SEND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, mlen);
  endtask

  // in-sequence unit acknowledging a random part of what was sent
  task automatic put_next(int len);
    put_unit(chk.acked_fsn + $urandom_range(0, chk.queued), chk.remote_bib,
             chk.lnk_bsn + 7'd1, len, ST_N);
  endtask

  task automatic put_noise();
    put_event($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  // drain every expected result, then let the block settle before a write
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // remote walks through O then N or E, then an in-sequence FISU ends proving early
  task automatic bring_up(logic emg);
    put_simple(OP_ALIGN, emg);
    put_unit(7'd127, 1'b1, 7'd127, 1, ST_O);
    put_unit(7'd127, 1'b1, 7'd127, 1, emg ? ST_E : ST_N);
    put_next(0);
    put_simple(OP_TICK);
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd1;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    int n;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: idle link, bad opcodes, bad lengths, refused sends, then error, start, LSSU status and pause events
    put_simple(OP_TICK);
    put_simple(4'd9);
    put_simple(4'd15);
    put_event(OP_RX, 7'h7f, 1, 7'h7f, 1, 6'd0, 9'd0, 8'hff, 1, 9'h1ff);
    put_event(OP_RX, 0, 0, 0, 0, 6'd0, 9'd2, 0, 0, 0);
    put_event(OP_RX, 0, 0, 0, 0, 6'd5, 9'd9, 0, 0, 0);
    put_send(9'd100);
    put_simple(OP_ERROR);
    put_simple(OP_UP, 1);
    put_unit(7'd0, 0, 7'd0, 2, ST_B);
    put_simple(OP_RESUME, 0);
    put_unit(7'd0, 0, 7'd0, 1, 8'd7);
    put_simple(OP_PAUSE);
    // emergency alignment to service, long and short units, bad sequence
    bring_up(1'b1);
    put_send(9'd272);
    put_send(9'd3);
    put_send(9'd2);
    put_event(OP_RX, chk.lnk_fsn, chk.remote_bib, chk.lnk_bsn + 7'd1, 0, 6'd63, 9'd275,
              0, 0, 0);
    put_unit(7'd0, 0, chk.lnk_bsn + 7'd9, 5, 0);
    put_unit(chk.acked_fsn, ~chk.remote_bib, chk.lnk_bsn, 0, 0);
    put_unit(chk.lnk_fsn, chk.remote_bib, chk.lnk_bsn, 1, 8'd6);
    put_unit(chk.lnk_fsn, chk.remote_bib, chk.lnk_bsn, 1, ST_B);
    put_simple(OP_DOWN);
    wait_idle();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_MAX_ERRORS, (ph == 0) ? 16'd0 : (ph == 1) ? 16'h1ff : $urandom_range(0, 511));
      write_reg(REG_AUTOSTART, (ph == 1) ? 16'd0 : $urandom_range(0, 1));
      write_reg(REG_FILL_LINK, ph[0]);
      write_reg(REG_FLUSH, (ph == 2) ? 16'd1 : ($urandom_range(0, 2) == 0));
      write_reg(REG_RESEND_TICKS, (ph == 0) ? 16'hffff : pick_period());
      write_reg(REG_ABORT_TICKS, (ph == 0) ? 16'hffff : (ph == 3) ? 16'd0 : pick_period());
      write_reg(REG_FILL_TICKS, (ph == 0) ? 16'hffff : pick_period());
      bring_up($urandom_range(0, 1));
      n = 0;
      while (n < 13) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: put_send($urandom_range(0, 20) == 0 ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 272));
          4, 5, 6:    put_next($urandom_range(0, 3) == 0 ? $urandom_range(3, 272) : 0);
          7, 8, 9:    put_simple(OP_TICK);
          10:         put_simple(OP_ERROR);
          11:         put_unit(chk.acked_fsn, $urandom, $urandom, $urandom_range(0, 2),
                               $urandom);
          12:         bring_up($urandom_range(0, 1));
          13:         put_simple($urandom_range(OP_DOWN, OP_RESUME), $urandom);
          default:    put_noise();
        endcase
        n++;
      end
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[ss7_mtp2_link_control_unit.f]
+incdir+design
design/ss7l_pkg.sv
design/ss7l_step.sv
design/ss7l_txq.sv
design/ss7_mtp2_link_control_unit.sv
verif/ss7_link_checker.sv
verif/ss7_mtp2_link_control_unit_tb.sv
